FILE: design/e2r_pkg.sv
// Package: shared widths, CORDIC constants and arctangent table.
package e2r_pkg;

  localparam int ANGLE_W = 16;
  localparam int ELEM_W = 16;
  localparam int Q30_W = 33;
  localparam int Z_W = 32;
  localparam int MAX_STAGES = 24;
  localparam int DEF_SINCOS_STAGES = 16;
  localparam logic signed [ANGLE_W-1:0] PI_Q13 = 16'sd25736;
  localparam logic signed [ANGLE_W-1:0] HALF_PI_Q13 = 16'sd12868;
  localparam logic signed [Q30_W-1:0] GAIN_Q30 = 33'sd652032874;
  localparam logic signed [ELEM_W-1:0] ONE_Q14 = 16'sd16384;

  function automatic logic signed [Z_W-1:0] atan_q28(input int idx);
    logic signed [Z_W-1:0] r;
    begin
      case (idx)
        0: r = 32'sd210828714;
        1: r = 32'sd124459457;
        2: r = 32'sd65760959;
        3: r = 32'sd33381290;
        4: r = 32'sd16755422;
        5: r = 32'sd8385879;
        6: r = 32'sd4193963;
        7: r = 32'sd2097109;
        8: r = 32'sd1048571;
        9: r = 32'sd524287;
        default: r = Z_W'(32'sd262144 >>> (idx - 10));
      endcase
      return r;
    end
  endfunction

  function automatic logic signed [Q30_W-1:0] mul_q30(
    input logic signed [Q30_W-1:0] a,
    input logic signed [Q30_W-1:0] b
  );
    logic signed [2*Q30_W-1:0] p;
    begin
      p = a * b + (66'sd1 <<< 29);
      return Q30_W'(p >>> 30);
    end
  endfunction

  function automatic logic signed [ELEM_W-1:0] to_out(input logic signed [Q30_W+1:0] v);
    logic signed [Q30_W+1:0] r;
    begin
      r = (v + 35'sd32768) >>> 16;
      if (r > 35'sd16384) r = 35'sd16384;
      if (r < -35'sd16384) r = -35'sd16384;
      return ELEM_W'(r);
    end
  endfunction

endpackage

FILE: design/euler_to_rotation_matrix.sv
// Top level: Z-Y-X Euler angles to rotation matrix, CORDIC cell chain.
//   channel | signals                                 | dir
//   in      | valid, stall, roll/pitch/yaw_angle      | sink
//   out     | out_valid, out_stall, m00..m22          | source
// One beat per cycle unless stalled; registered steps in order: range reduce,
// one CORDIC cell per stage, three product/round stages.
// Synchronous reset clears valid bits only. The whole chain advances
// when the output register is empty or taken; stall = out held & out_stall.
module euler_to_rotation_matrix #(
  parameter int SINCOS_STAGES = e2r_pkg::DEF_SINCOS_STAGES
) (
  input  logic clk,
  input  logic rst,
  input  logic valid,
  output logic stall,
  input  logic signed [e2r_pkg::ANGLE_W-1:0] roll_angle,
  input  logic signed [e2r_pkg::ANGLE_W-1:0] pitch_angle,
  input  logic signed [e2r_pkg::ANGLE_W-1:0] yaw_angle,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [e2r_pkg::ELEM_W-1:0] m00,
  output logic signed [e2r_pkg::ELEM_W-1:0] m01,
  output logic signed [e2r_pkg::ELEM_W-1:0] m02,
  output logic signed [e2r_pkg::ELEM_W-1:0] m10,
  output logic signed [e2r_pkg::ELEM_W-1:0] m11,
  output logic signed [e2r_pkg::ELEM_W-1:0] m12,
  output logic signed [e2r_pkg::ELEM_W-1:0] m20,
  output logic signed [e2r_pkg::ELEM_W-1:0] m21,
  output logic signed [e2r_pkg::ELEM_W-1:0] m22
);
  import e2r_pkg::*;

  localparam int N = (SINCOS_STAGES > MAX_STAGES) ? MAX_STAGES : SINCOS_STAGES;

  logic adv;
  logic signed [ANGLE_W-1:0] ang [3];
  logic signed [ANGLE_W-1:0] red [3];
  logic [2:0] fl_next;

  logic cv [N+1];
  logic signed [Q30_W-1:0] cx [N+1][3];
  logic signed [Q30_W-1:0] cy [N+1][3];
  logic signed [Z_W-1:0] cz [N+1][3];
  logic [2:0] cf [N+1];

  logic signed [Q30_W-1:0] s_fix [3];
  logic signed [Q30_W-1:0] c_fix [3];
  logic signed [ELEM_W-1:0] m [9];

  assign adv = !(out_valid && out_stall);
  assign stall = !adv;

  assign ang[0] = roll_angle;
  assign ang[1] = pitch_angle;
  assign ang[2] = yaw_angle;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      red[k] = ang[k];
      if (red[k] > PI_Q13) red[k] = PI_Q13;
      if (red[k] < -PI_Q13) red[k] = -PI_Q13;
      fl_next[k] = 1'b0;
      if (red[k] > HALF_PI_Q13) begin
        red[k] = red[k] - PI_Q13;
        fl_next[k] = 1'b1;
      end else if (red[k] < -HALF_PI_Q13) begin
        red[k] = red[k] + PI_Q13;
        fl_next[k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (adv) begin
      cv[0] <= valid;
    end
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        cx[0][k] <= GAIN_Q30;
        cy[0][k] <= '0;
        cz[0][k] <= {{(Z_W-ANGLE_W-15){red[k][ANGLE_W-1]}}, red[k], 15'd0};
      end
      cf[0] <= fl_next;
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    e2r_cell #(.IDX(g)) u_cell (
      .clk(clk), .rst(rst), .adv(adv),
      .vld_in(cv[g]), .x_in(cx[g]), .y_in(cy[g]), .z_in(cz[g]), .flip_in(cf[g]),
      .vld(cv[g+1]), .x(cx[g+1]), .y(cy[g+1]), .z(cz[g+1]), .flip(cf[g+1])
    );
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s_fix[k] = cf[N][k] ? -cy[N][k] : cy[N][k];
      c_fix[k] = cf[N][k] ? -cx[N][k] : cx[N][k];
    end
  end

  e2r_mat u_mat (
    .clk(clk), .rst(rst), .adv(adv),
    .vld_in(cv[N]), .s_in(s_fix), .c_in(c_fix),
    .vld(out_valid), .m(m)
  );

  assign m00 = m[0];
  assign m01 = m[1];
  assign m02 = m[2];
  assign m10 = m[3];
  assign m11 = m[4];
  assign m12 = m[5];
  assign m20 = m[6];
  assign m21 = m[7];
  assign m22 = m[8];
endmodule

FILE: design/e2r_cell.sv
// CORDIC rotation cell: one stage for the three angles, registered.
module e2r_cell #(
  parameter int IDX = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic vld_in,
  input  logic signed [e2r_pkg::Q30_W-1:0] x_in [3],
  input  logic signed [e2r_pkg::Q30_W-1:0] y_in [3],
  input  logic signed [e2r_pkg::Z_W-1:0] z_in [3],
  input  logic [2:0] flip_in,
  output logic vld,
  output logic signed [e2r_pkg::Q30_W-1:0] x [3],
  output logic signed [e2r_pkg::Q30_W-1:0] y [3],
  output logic signed [e2r_pkg::Z_W-1:0] z [3],
  output logic [2:0] flip
);
  import e2r_pkg::*;

  logic signed [Q30_W-1:0] x_next [3];
  logic signed [Q30_W-1:0] y_next [3];
  logic signed [Z_W-1:0] z_next [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (!z_in[k][Z_W-1]) begin
        x_next[k] = x_in[k] - (y_in[k] >>> IDX);
        y_next[k] = y_in[k] + (x_in[k] >>> IDX);
        z_next[k] = z_in[k] - atan_q28(IDX);
      end else begin
        x_next[k] = x_in[k] + (y_in[k] >>> IDX);
        y_next[k] = y_in[k] - (x_in[k] >>> IDX);
        z_next[k] = z_in[k] + atan_q28(IDX);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (adv) begin
      vld <= vld_in;
    end
    if (adv) begin
      x <= x_next;
      y <= y_next;
      z <= z_next;
      flip <= flip_in;
    end
  end
endmodule

FILE: design/e2r_mat.sv
// Matrix stage: products of sines and cosines, rounding and saturation.
module e2r_mat (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic vld_in,
  input  logic signed [e2r_pkg::Q30_W-1:0] s_in [3],
  input  logic signed [e2r_pkg::Q30_W-1:0] c_in [3],
  output logic vld,
  output logic signed [e2r_pkg::ELEM_W-1:0] m [9]
);
  import e2r_pkg::*;

  // stage a: two-factor products
  logic va, vb;
  logic signed [Q30_W-1:0] sr, cr, sp_a, sr_a, cr_a;
  logic signed [Q30_W-1:0] cysp, sysp, cycp, sycp, cpsr, cpcr, sycr, sysr, cycr, cysr;
  // stage b: three-factor terms
  logic signed [Q30_W-1:0] t1, t2, t4, t5;
  logic signed [Q30_W-1:0] cycp_b, sycp_b, cpsr_b, cpcr_b, sycr_b, sysr_b, cycr_b, cysr_b, sp_b;

  assign sr = s_in[0];
  assign cr = c_in[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vld <= 1'b0;
    end else if (adv) begin
      va <= vld_in;
      vb <= va;
      vld <= vb;
    end
    if (adv) begin
      cysp <= mul_q30(c_in[2], s_in[1]);
      sysp <= mul_q30(s_in[2], s_in[1]);
      cycp <= mul_q30(c_in[2], c_in[1]);
      sycp <= mul_q30(s_in[2], c_in[1]);
      cpsr <= mul_q30(c_in[1], sr);
      cpcr <= mul_q30(c_in[1], cr);
      sycr <= mul_q30(s_in[2], cr);
      sysr <= mul_q30(s_in[2], sr);
      cycr <= mul_q30(c_in[2], cr);
      cysr <= mul_q30(c_in[2], sr);
      sp_a <= s_in[1];
      sr_a <= sr;
      cr_a <= cr;

      t1 <= mul_q30(cysp, sr_a);
      t2 <= mul_q30(cysp, cr_a);
      t4 <= mul_q30(sysp, sr_a);
      t5 <= mul_q30(sysp, cr_a);
      cycp_b <= cycp;
      sycp_b <= sycp;
      cpsr_b <= cpsr;
      cpcr_b <= cpcr;
      sycr_b <= sycr;
      sysr_b <= sysr;
      cycr_b <= cycr;
      cysr_b <= cysr;
      sp_b <= sp_a;

      m[0] <= to_out(35'(cycp_b));
      m[1] <= to_out(35'(t1) - 35'(sycr_b));
      m[2] <= to_out(35'(t2) + 35'(sysr_b));
      m[3] <= to_out(35'(sycp_b));
      m[4] <= to_out(35'(t4) + 35'(cycr_b));
      m[5] <= to_out(35'(t5) - 35'(cysr_b));
      m[6] <= to_out(-35'(sp_b));
      m[7] <= to_out(35'(cpsr_b));
      m[8] <= to_out(35'(cpcr_b));
    end
  end
endmodule

FILE: verif/e2r_checker.sv
// Checker: watches both channels, predicts rotation matrix elements, compares beats.
module e2r_checker #(
  parameter int STAGES = e2r_pkg::DEF_SINCOS_STAGES
) (
  input  logic clk,
  input  logic rst,
  input  logic valid,
  input  logic stall,
  input  logic signed [15:0] roll_angle,
  input  logic signed [15:0] pitch_angle,
  input  logic signed [15:0] yaw_angle,
  input  logic out_valid,
  input  logic out_stall,
  input  logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22,
  output int   errors,
  output int   pending
);
  typedef logic signed [15:0] elem_t;
  typedef struct packed {
    elem_t e00, e01, e02, e10, e11, e12, e20, e21, e22;
  } rot_beat_t;

  rot_beat_t expected_q[$];

  localparam longint ATAN[24] = '{
    210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
    4193963, 2097109, 1048571, 524287, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048,
    1024, 512, 256, 128, 64, 32};

  function automatic longint mulq(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic elem_t rnd(longint v);
    longint r;
    r = (v + 32768) >>> 16;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return elem_t'(r);
  endfunction

  function automatic void sincos(input logic signed [15:0] ang, output longint s,
                                 output longint c);
    longint a, x, y, z, dx, dy;
    bit flip;
    a = ang;
    flip = 0;
    x = 652032874;
    y = 0;
    if (a > 25736) a = 25736;
    if (a < -25736) a = -25736;
    if (a > 12868) begin
      a -= 25736; flip = 1;
    end else if (a < -12868) begin
      a += 25736; flip = 1;
    end
    z = a * 32768;
    for (int i = 0; i < STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN[i];
      end else begin
        x += dx; y -= dy; z += ATAN[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    s = y;
    c = x;
  endfunction

  function automatic rot_beat_t rotation(elem_t r, elem_t p, elem_t w);
    longint sr, cr, sp, cp, sy, cy, cysp, sysp;
    rot_beat_t m;
    sincos(r, sr, cr);
    sincos(p, sp, cp);
    sincos(w, sy, cy);
    cysp = mulq(cy, sp);
    sysp = mulq(sy, sp);
    m.e00 = rnd(mulq(cy, cp));
    m.e01 = rnd(mulq(cysp, sr) - mulq(sy, cr));
    m.e02 = rnd(mulq(cysp, cr) + mulq(sy, sr));
    m.e10 = rnd(mulq(sy, cp));
    m.e11 = rnd(mulq(sysp, sr) + mulq(cy, cr));
    m.e12 = rnd(mulq(sysp, cr) - mulq(cy, sr));
    m.e20 = rnd(-sp);
    m.e21 = rnd(mulq(cp, sr));
    m.e22 = rnd(mulq(cp, cr));
    return m;
  endfunction

  initial errors = 0;
  assign pending = expected_q.size();

  always @(posedge clk) begin
    rot_beat_t got, want;
    if (!rst) begin
      if (valid && !stall)
        expected_q.push_back(rotation(roll_angle, pitch_angle, yaw_angle));
      if (out_valid && !out_stall) begin
        got = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected beat: %p", got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) $display("beat differs: expected %p actual %p", want, got);
          end
        end
      end
    end
  end
endmodule

FILE: verif/tb_euler_to_rotation_matrix.sv
// Testbench top: drives angle beats with random idling and gives the verdict.
module tb_euler_to_rotation_matrix;
  logic clk = 0, rst = 1, valid = 0, out_stall = 0, stall, out_valid;
  logic signed [15:0] roll_angle = 0, pitch_angle = 0, yaw_angle = 0;
  logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  int errors, pending, cycles = 0;
  bit calm = 0;

  euler_to_rotation_matrix uut (.*);
  e2r_checker chk (.*);

  initial forever #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > 200000) begin
      $display("euler_to_rotation_matrix: mismatch");
      $finish;
    end
  end

  // receiver stall bursts
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 18);
        out_stall <= 1;
        repeat (n) @(negedge clk);
        out_stall <= 0;
      end
    end
  end

  function automatic logic signed [15:0] pick_angle();
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? 16'sd12868 + 16'($urandom_range(0, 2)) - 16'sd1
                                     : -16'sd12868 + 16'($urandom_range(0, 2)) - 16'sd1;
      2: return $urandom_range(0, 1) ? 16'sd25736 : -16'sd25736;
      default: return 16'($urandom_range(0, 51472)) - 16'sd25736;
    endcase
  endfunction

  task automatic send(input logic signed [15:0] r, p, w);
    roll_angle <= r; pitch_angle <= p; yaw_angle <= w;
    valid <= 1;
    do @(posedge clk); while (stall);
    @(negedge clk);
  endtask

  initial begin
    logic signed [15:0] corners[10];
    corners = '{16'sd0, 16'sd12868, -16'sd12868, 16'sd12869, -16'sd12869,
                16'sd25736, -16'sd25736, 16'sh7fff, 16'sh8000, 16'sd4096};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    foreach (corners[i]) send(corners[i], corners[(i + 3) % 10], corners[(i + 7) % 10]);
    send(16'sd1, -16'sd1, 16'sh7ffe);
    for (int k = 0; k < 500; k++) begin
      if (k == 420) calm = 1;
      if (!calm && $urandom_range(0, 7) == 0) begin
        valid <= 0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
      send(pick_angle(), pick_angle(), pick_angle());
    end
    valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    if (errors == 0) $display("euler_to_rotation_matrix: match");
    else $display("euler_to_rotation_matrix: mismatch");
    $finish;
  end
endmodule
